/* rtl/ntt22_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and modular helper functions for the radix-2x2 butterfly.
// It has no dependencies. The layer module and the top level import it.

package ntt22_pkg;

    localparam int unsigned CW = 23;

    typedef logic [CW-1:0] t_coef;

    // Modulus and the constants derived from it.
    localparam t_coef Q         = 23'd8380417;
    localparam t_coef HALF_Q_UP = 23'((24'(Q) + 24'd1) / 24'd2);

    // Barrett factor floor(2^46 / q), which fits in 24 bits.
    localparam logic [63:0] MU_WIDE = (64'd1 << 46) / 64'(Q);
    localparam logic [23:0] MU      = MU_WIDE[23:0];

    // Word entering one butterfly layer: two pairs, their twiddles, and the
    // twiddles that the following layer will need.
    typedef struct packed {
        logic  inv;
        t_coef x0;
        t_coef y0;
        t_coef w0;
        t_coef x1;
        t_coef y1;
        t_coef w1;
        t_coef nw0;
        t_coef nw1;
    } t_bfly_in;

    // Word leaving one butterfly layer.
    typedef struct packed {
        logic  inv;
        t_coef x0;
        t_coef y0;
        t_coef x1;
        t_coef y1;
        t_coef nw0;
        t_coef nw1;
    } t_bfly_out;

    // Reduces a 23-bit value below 2^23 into 0..q-1.
    function automatic t_coef canon_q(input t_coef x);
        return (x >= Q) ? (x - Q) : x;
    endfunction

    // Modular addition of two canonical residues.
    function automatic t_coef add_q(input t_coef x, input t_coef y);
        logic [CW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, Q}) ? CW'(s - {1'b0, Q}) : s[CW-1:0];
    endfunction

    // Modular subtraction of two canonical residues.
    function automatic t_coef sub_q(input t_coef x, input t_coef y);
        logic [CW:0] s;
        s = {1'b0, x} + {1'b0, Q} - {1'b0, y};
        return (x >= y) ? (x - y) : s[CW-1:0];
    endfunction

    // Division by two modulo q of a canonical residue.
    function automatic t_coef half_q(input t_coef x);
        return (x >> 1) + (x[0] ? HALF_Q_UP : '0);
    endfunction

endpackage

`default_nettype wire

/* rtl/ntt22_layer.sv */
`timescale 1ns / 1ps
`default_nettype none
// One butterfly layer: two Cooley-Tukey or Gentleman-Sande butterflies in six stages.
// It depends on ntt22_pkg for the word types, the modulus and the helpers.

module ntt22_layer
    import ntt22_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_bfly_in  i_word,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_bfly_out      o_word
);

    localparam int unsigned NSTG = 6;

    typedef struct packed {
        logic        inv;
        t_coef       x0;
        t_coef       x1;
        t_coef       nw0;
        t_coef       nw1;
        logic [45:0] p0;
        logic [45:0] p1;
    } t_mul;

    typedef struct packed {
        logic        inv;
        t_coef       x0;
        t_coef       x1;
        t_coef       nw0;
        t_coef       nw1;
        logic [24:0] plo0;
        logic [24:0] plo1;
        logic [23:0] qt0;
        logic [23:0] qt1;
    } t_bar;

    typedef struct packed {
        logic        inv;
        t_coef       x0;
        t_coef       x1;
        t_coef       nw0;
        t_coef       nw1;
        logic [24:0] r0;
        logic [24:0] r1;
    } t_rem;

    typedef struct packed {
        logic  inv;
        t_coef x0;
        t_coef x1;
        t_coef nw0;
        t_coef nw1;
        t_coef t0;
        t_coef t1;
    } t_red;

    // The Barrett remainder lies below 3q; two candidate subtractions settle it.
    function automatic t_coef reduce_3q(input logic [24:0] r);
        logic [24:0] q1;
        logic [24:0] q2;
        q1 = 25'(Q);
        q2 = 25'(Q) << 1;
        if (r >= q2) begin
            return CW'(r - q2);
        end else if (r >= q1) begin
            return CW'(r - q1);
        end
        return r[CW-1:0];
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    t_bfly_in  r_pre;
    t_mul      r_mul;
    t_bar      r_bar;
    t_rem      r_rem;
    t_red      r_red;
    t_bfly_out r_post;

    logic [47:0] w_qp0;
    logic [47:0] w_qp1;
    logic [46:0] w_qq0;
    logic [46:0] w_qq1;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_word  = r_post;

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Barrett quotient estimate and its multiple of q.
    assign w_qp0 = 48'(r_mul.p0[45:22]) * 48'(MU);
    assign w_qp1 = 48'(r_mul.p1[45:22]) * 48'(MU);
    assign w_qq0 = 47'(r_bar.qt0) * 47'(Q);
    assign w_qq1 = 47'(r_bar.qt1) * 47'(Q);

    // Datapath stages; payload needs no reset.
    always_ff @(posedge i_clk) begin
        // Pre stage: the inverse butterfly adds, subtracts and halves first.
        if (w_en[0]) begin
            r_pre.inv <= i_word.inv;
            r_pre.w0  <= i_word.w0;
            r_pre.w1  <= i_word.w1;
            r_pre.nw0 <= i_word.nw0;
            r_pre.nw1 <= i_word.nw1;
            if (i_word.inv) begin
                r_pre.x0 <= half_q(add_q(i_word.x0, i_word.y0));
                r_pre.y0 <= half_q(sub_q(i_word.x0, i_word.y0));
                r_pre.x1 <= half_q(add_q(i_word.x1, i_word.y1));
                r_pre.y1 <= half_q(sub_q(i_word.x1, i_word.y1));
            end else begin
                r_pre.x0 <= i_word.x0;
                r_pre.y0 <= i_word.y0;
                r_pre.x1 <= i_word.x1;
                r_pre.y1 <= i_word.y1;
            end
        end
        // Twiddle products.
        if (w_en[1]) begin
            r_mul.inv <= r_pre.inv;
            r_mul.x0  <= r_pre.x0;
            r_mul.x1  <= r_pre.x1;
            r_mul.nw0 <= r_pre.nw0;
            r_mul.nw1 <= r_pre.nw1;
            r_mul.p0  <= 46'(r_pre.y0) * 46'(r_pre.w0);
            r_mul.p1  <= 46'(r_pre.y1) * 46'(r_pre.w1);
        end
        // Quotient estimate.
        if (w_en[2]) begin
            r_bar.inv  <= r_mul.inv;
            r_bar.x0   <= r_mul.x0;
            r_bar.x1   <= r_mul.x1;
            r_bar.nw0  <= r_mul.nw0;
            r_bar.nw1  <= r_mul.nw1;
            r_bar.plo0 <= r_mul.p0[24:0];
            r_bar.plo1 <= r_mul.p1[24:0];
            r_bar.qt0  <= w_qp0[47:24];
            r_bar.qt1  <= w_qp1[47:24];
        end
        // Remainder, exact modulo 2^25 since it stays below 3q.
        if (w_en[3]) begin
            r_rem.inv <= r_bar.inv;
            r_rem.x0  <= r_bar.x0;
            r_rem.x1  <= r_bar.x1;
            r_rem.nw0 <= r_bar.nw0;
            r_rem.nw1 <= r_bar.nw1;
            r_rem.r0  <= r_bar.plo0 - w_qq0[24:0];
            r_rem.r1  <= r_bar.plo1 - w_qq1[24:0];
        end
        // Final correction into 0..q-1.
        if (w_en[4]) begin
            r_red.inv <= r_rem.inv;
            r_red.x0  <= r_rem.x0;
            r_red.x1  <= r_rem.x1;
            r_red.nw0 <= r_rem.nw0;
            r_red.nw1 <= r_rem.nw1;
            r_red.t0  <= reduce_3q(r_rem.r0);
            r_red.t1  <= reduce_3q(r_rem.r1);
        end
        // Post stage: the forward butterfly adds and subtracts the product.
        if (w_en[5]) begin
            r_post.inv <= r_red.inv;
            r_post.nw0 <= r_red.nw0;
            r_post.nw1 <= r_red.nw1;
            if (r_red.inv) begin
                r_post.x0 <= r_red.x0;
                r_post.y0 <= r_red.t0;
                r_post.x1 <= r_red.x1;
                r_post.y1 <= r_red.t1;
            end else begin
                r_post.x0 <= add_q(r_red.x0, r_red.t0);
                r_post.y0 <= sub_q(r_red.x0, r_red.t0);
                r_post.x1 <= add_q(r_red.x1, r_red.t1);
                r_post.y1 <= sub_q(r_red.x1, r_red.t1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/ntt_2x2_butterfly_mod_q.sv */
`timescale 1ns / 1ps
`default_nettype none
// Radix-2x2 NTT butterfly unit modulo q = 8380417, two layers on four coefficients.
// It depends on ntt22_pkg and instantiates ntt22_layer twice.
//
// Usage:
//   The input channel (i_valid / o_ready) carries one word: the mode, four
//   coefficients and three twiddles. The output channel (o_valid / i_ready)
//   returns one word of four canonical coefficients for every input word.
//   Mode 0 runs forward Cooley-Tukey butterflies, mode 1 runs inverse
//   Gentleman-Sande butterflies with halving; inverse twiddles are given
//   already negated. Operands at or above q are reduced first.
//   The pipeline has one input reduction stage, six stages per layer
//   (pre add, multiply, Barrett estimate, remainder, correction, post add)
//   and one output register. Throughput is one word per cycle when not full.
//   When the receiver stalls, words pile up stage by stage; o_ready stays
//   high while any stage is empty and drops only once the pipeline is full.
//   Nothing is lost or repeated. A synchronous active-low reset empties the
//   pipeline; there is no other state.

module ntt_2x2_butterfly_mod_q
    import ntt22_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_cmd,
    input  wire logic [22:0]   i_coef_0,
    input  wire logic [22:0]   i_coef_1,
    input  wire logic [22:0]   i_coef_2,
    input  wire logic [22:0]   i_coef_3,
    input  wire logic [22:0]   i_tw_a,
    input  wire logic [22:0]   i_tw_b,
    input  wire logic [22:0]   i_tw_c,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [22:0]        o_out_0,
    output logic [22:0]        o_out_1,
    output logic [22:0]        o_out_2,
    output logic [22:0]        o_out_3
);

    logic      r_vld_in;
    logic      r_vld_out;
    t_bfly_in  r_in;
    logic      w_en_in;
    logic      w_en_out;

    logic      w_l1_ready;
    logic      w_l1_valid;
    t_bfly_out w_l1_word;
    logic      w_l2_ready;
    logic      w_l2_valid;
    t_bfly_in  w_l2_in;
    t_bfly_out w_l2_word;

    t_coef w_c0;
    t_coef w_c1;
    t_coef w_c2;
    t_coef w_c3;
    t_coef w_wa;
    t_coef w_wb;
    t_coef w_wc;

    t_coef r_out_0;
    t_coef r_out_1;
    t_coef r_out_2;
    t_coef r_out_3;

    assign w_en_in  = !r_vld_in || w_l1_ready;
    assign w_en_out = !r_vld_out || i_ready;
    assign o_ready  = w_en_in;
    assign o_valid  = r_vld_out;

    // Input operands reduced into 0..q-1.
    assign w_c0 = canon_q(i_coef_0);
    assign w_c1 = canon_q(i_coef_1);
    assign w_c2 = canon_q(i_coef_2);
    assign w_c3 = canon_q(i_coef_3);
    assign w_wa = canon_q(i_tw_a);
    assign w_wb = canon_q(i_tw_b);
    assign w_wc = canon_q(i_tw_c);

    // Valid bits of the input and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in  <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            if (w_en_in) begin
                r_vld_in <= i_valid;
            end
            if (w_en_out) begin
                r_vld_out <= w_l2_valid;
            end
        end
    end

    // Input stage: pick the first-layer pairs and the twiddles for both layers.
    always_ff @(posedge i_clk) begin
        if (w_en_in) begin
            r_in.inv <= i_cmd;
            r_in.x0  <= w_c0;
            r_in.w0  <= w_wa;
            r_in.y1  <= w_c3;
            if (i_cmd) begin
                r_in.y0  <= w_c1;
                r_in.x1  <= w_c2;
                r_in.w1  <= w_wb;
                r_in.nw0 <= w_wc;
                r_in.nw1 <= w_wc;
            end else begin
                r_in.y0  <= w_c2;
                r_in.x1  <= w_c1;
                r_in.w1  <= w_wa;
                r_in.nw0 <= w_wb;
                r_in.nw1 <= w_wc;
            end
        end
    end

    ntt22_layer u_layer1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_in),
        .o_ready (w_l1_ready),
        .i_word  (r_in),
        .o_valid (w_l1_valid),
        .i_ready (w_l2_ready),
        .o_word  (w_l1_word)
    );

    // The second-layer pairs take the same lanes in both modes.
    always_comb begin
        w_l2_in.inv = w_l1_word.inv;
        w_l2_in.x0  = w_l1_word.x0;
        w_l2_in.y0  = w_l1_word.x1;
        w_l2_in.x1  = w_l1_word.y0;
        w_l2_in.y1  = w_l1_word.y1;
        w_l2_in.w0  = w_l1_word.nw0;
        w_l2_in.w1  = w_l1_word.nw1;
        w_l2_in.nw0 = '0;
        w_l2_in.nw1 = '0;
    end

    ntt22_layer u_layer2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_l1_valid),
        .o_ready (w_l2_ready),
        .i_word  (w_l2_in),
        .o_valid (w_l2_valid),
        .i_ready (w_en_out),
        .o_word  (w_l2_word)
    );

    // Output register: put the coefficients back in their natural order.
    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_0 <= w_l2_word.x0;
            r_out_3 <= w_l2_word.y1;
            if (w_l2_word.inv) begin
                r_out_1 <= w_l2_word.x1;
                r_out_2 <= w_l2_word.y0;
            end else begin
                r_out_1 <= w_l2_word.y0;
                r_out_2 <= w_l2_word.x1;
            end
        end
    end

    assign o_out_0 = r_out_0;
    assign o_out_1 = r_out_1;
    assign o_out_2 = r_out_2;
    assign o_out_3 = r_out_3;

    // Every delivered coefficient is a canonical residue.
    a_out_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_0 < Q) && (o_out_1 < Q) && (o_out_2 < Q) && (o_out_3 < Q))
        else $error("output coefficient not reduced below q");

    // A word held in the input stage is not dropped while the first layer is full.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_in && !w_l1_ready |=> r_vld_in)
        else $error("input stage word lost during a stall");

    // The input is refused only when the input stage holds a word.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_vld_in && !w_l1_ready)
        else $error("input refused while the input stage could advance");

endmodule

`default_nettype wire

/* bench/tb_ntt_2x2_butterfly_mod_q.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the radix-2x2 butterfly unit modulo q.
// It depends on ntt22_pkg and ntt_2x2_butterfly_mod_q. A directed table runs first,
// then random words, checked against a predictor of both butterfly modes.

module tb_ntt_2x2_butterfly_mod_q
    import ntt22_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WORDS_PER_PASS = 478;
    localparam logic [22:0] ALL_ONES = 23'h7FFFFF;

    // Mode codes carried by i_cmd.
    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_INV = 1'b1;

    // One input word: mode, four coefficients, three twiddles (a, b, c).
    typedef struct packed {
        logic        inv;
        t_coef [3:0] coef;
        t_coef [2:0] tw;
    } t_group;

    typedef t_coef [3:0] t_quad;
    typedef t_coef [1:0] t_pair;

    // Directed row; a fixed answer is stored where it is obvious.
    typedef struct packed {
        t_group g;
        logic   fixed;
        t_quad  want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = 1'b0;
    logic [22:0] i_coef_0 = '0;
    logic [22:0] i_coef_1 = '0;
    logic [22:0] i_coef_2 = '0;
    logic [22:0] i_coef_3 = '0;
    logic [22:0] i_tw_a = '0;
    logic [22:0] i_tw_b = '0;
    logic [22:0] i_tw_c = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [22:0] o_out_0;
    logic [22:0] o_out_1;
    logic [22:0] o_out_2;
    logic [22:0] o_out_3;

    t_quad    expected_quads[$];
    t_dir_row directed_rows[$];
    int       send_idle_pct = 8;
    int       recv_idle_pct = 61;
    int       n_errors = 0;
    int       quiet_cycles = 0;

    ntt_2x2_butterfly_mod_q dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .i_coef_0 (i_coef_0),
        .i_coef_1 (i_coef_1),
        .i_coef_2 (i_coef_2),
        .i_coef_3 (i_coef_3),
        .i_tw_a   (i_tw_a),
        .i_tw_b   (i_tw_b),
        .i_tw_c   (i_tw_c),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out_0  (o_out_0),
        .o_out_1  (o_out_1),
        .o_out_2  (o_out_2),
        .o_out_3  (o_out_3)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Modular arithmetic on canonical residues.
    function automatic t_coef mod_fold(input t_coef x);
        return (x >= Q) ? t_coef'(x - Q) : x;
    endfunction

    function automatic t_coef mod_add(input t_coef x, input t_coef y);
        logic [23:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, Q}) ? t_coef'(s - {1'b0, Q}) : s[22:0];
    endfunction

    function automatic t_coef mod_sub(input t_coef x, input t_coef y);
        logic [23:0] s;
        s = {1'b0, x} + {1'b0, Q} - {1'b0, y};
        return (x >= y) ? t_coef'(x - y) : s[22:0];
    endfunction

    function automatic t_coef mod_mul(input t_coef x, input t_coef y);
        logic [63:0] p;
        p = (64'(x) * 64'(y)) % 64'(Q);
        return p[22:0];
    endfunction

    function automatic t_coef mod_half(input t_coef x);
        return x[0] ? t_coef'((x >> 1) + HALF_Q_UP) : t_coef'(x >> 1);
    endfunction

    // Cooley-Tukey pair: [1] gets x + y*w, [0] gets x - y*w.
    function automatic t_pair ct_pair(input t_coef x, input t_coef y, input t_coef w);
        t_coef t;
        t = mod_mul(y, w);
        return {mod_add(x, t), mod_sub(x, t)};
    endfunction

    // Gentleman-Sande pair with halving: [1] gets (x + y)/2, [0] gets ((x - y)/2)*w.
    function automatic t_pair gs_pair(input t_coef x, input t_coef y, input t_coef w);
        return {mod_half(mod_add(x, y)), mod_mul(mod_half(mod_sub(x, y)), w)};
    endfunction

    // Both butterfly layers on one word; operands at or above q are folded first.
    function automatic t_quad butterfly_2x2(input t_group g);
        t_coef c [4];
        t_coef w [3];
        t_pair p;
        t_quad r;
        for (int k = 0; k < 4; k++) c[k] = mod_fold(g.coef[k]);
        for (int k = 0; k < 3; k++) w[k] = mod_fold(g.tw[k]);
        if (g.inv == CMD_FWD) begin
            p = ct_pair(c[0], c[2], w[0]); c[0] = p[1]; c[2] = p[0];
            p = ct_pair(c[1], c[3], w[0]); c[1] = p[1]; c[3] = p[0];
            p = ct_pair(c[0], c[1], w[1]); c[0] = p[1]; c[1] = p[0];
            p = ct_pair(c[2], c[3], w[2]); c[2] = p[1]; c[3] = p[0];
        end else begin
            p = gs_pair(c[0], c[1], w[0]); c[0] = p[1]; c[1] = p[0];
            p = gs_pair(c[2], c[3], w[1]); c[2] = p[1]; c[3] = p[0];
            p = gs_pair(c[0], c[2], w[2]); c[0] = p[1]; c[2] = p[0];
            p = gs_pair(c[1], c[3], w[2]); c[1] = p[1]; c[3] = p[0];
        end
        for (int k = 0; k < 4; k++) r[k] = c[k];
        return r;
    endfunction

    // Mostly canonical residues, some over the full 23 bits, some extremes.
    function automatic t_coef rand_operand();
        int sel;
        int pick;
        sel = $urandom_range(99);
        if (sel < 78) return t_coef'($urandom_range(Q - 1));
        if (sel < 90) return t_coef'($urandom_range(ALL_ONES));
        pick = $urandom_range(4);
        case (pick)
            0: return '0;
            1: return t_coef'(1);
            2: return t_coef'(Q - 1);
            3: return Q;
            default: return ALL_ONES;
        endcase
    endfunction

    task automatic add_row(input logic inv, input t_coef c0, input t_coef c1,
                           input t_coef c2, input t_coef c3, input t_coef wa,
                           input t_coef wb, input t_coef wc, input logic fixed,
                           input t_quad want);
        t_dir_row row;
        row.g.inv  = inv;
        row.g.coef = {c3, c2, c1, c0};
        row.g.tw   = {wc, wb, wa};
        row.fixed  = fixed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Offers one word at a falling edge and returns at the falling edge after acceptance.
    task automatic send_group(input t_group g, input logic fixed, input t_quad want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_cmd    = g.inv;
        i_coef_0 = g.coef[0];
        i_coef_1 = g.coef[1];
        i_coef_2 = g.coef[2];
        i_coef_3 = g.coef[3];
        i_tw_a   = g.tw[0];
        i_tw_b   = g.tw[1];
        i_tw_c   = g.tw[2];
        i_valid  = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_quads.push_back(fixed ? want : butterfly_2x2(g));
        @(negedge i_clk);
    endtask

    // Lets the pipeline empty completely before going on.
    task automatic wait_until_drained();
        i_valid = 1'b0;
        while (expected_quads.size() != 0) @(negedge i_clk);
    endtask

    // Receiver readiness, redrawn every cycle.
    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker and count of cycles without any handshake.
    always @(posedge i_clk) begin : out_monitor
        t_quad got;
        t_quad want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_valid && i_ready) begin
                got = {o_out_3, o_out_2, o_out_1, o_out_0};
                if (expected_quads.size() == 0) begin
                    $error("output word %h with no word outstanding", got);
                    n_errors++;
                end else begin
                    want = expected_quads.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("o_out_%0d: expected %0d, actual %0d", k, want[k], got[k]);
                            n_errors++;
                        end
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    initial begin
        @(posedge i_rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Stimulus: directed table, then three random passes with different idling.
    initial begin
        t_group g;
        t_quad  none;
        none = '0;

        // Forward with zero twiddles copies coefficient 0 into every output.
        add_row(CMD_FWD, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0);
        add_row(CMD_INV, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0);
        add_row(CMD_FWD, Q - 1, 5, 7, 9, 0, 0, 0, 1'b1,
                {t_coef'(Q - 1), t_coef'(Q - 1), t_coef'(Q - 1), t_coef'(Q - 1)});
        // All ones folds to 2^23 - 1 - q = 8190.
        add_row(CMD_FWD, ALL_ONES, 0, 0, 0, 0, 0, 0, 1'b1,
                {t_coef'(8190), t_coef'(8190), t_coef'(8190), t_coef'(8190)});
        // Operands equal to q fold to zero.
        add_row(CMD_FWD, Q, Q, Q, Q, Q, Q, Q, 1'b1, '0);
        // Inverse with zero twiddles leaves a quarter of the sum in output 0.
        add_row(CMD_INV, 2, 0, 0, 0, 0, 0, 0, 1'b1, {t_coef'(0), t_coef'(0), t_coef'(0), HALF_Q_UP});
        add_row(CMD_FWD, 1, 0, 0, 0, 1, 1, 1, 1'b1,
                {t_coef'(1), t_coef'(1), t_coef'(1), t_coef'(1)});
        // Largest residues and largest raw operands in both modes.
        add_row(CMD_FWD, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, 1'b0, none);
        add_row(CMD_INV, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, Q - 1, 1'b0, none);
        add_row(CMD_FWD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, none);
        add_row(CMD_INV, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, none);
        // Odd values through the halving, and subtraction wrap-around.
        add_row(CMD_INV, 1, 0, 0, 0, 1, 1, 1, 1'b0, none);
        add_row(CMD_INV, 0, 1, 0, 1, Q - 1, Q - 1, Q - 1, 1'b0, none);
        add_row(CMD_FWD, 0, 0, 1, 1, 1, 1, 1, 1'b0, none);
        add_row(CMD_FWD, 123456, 7654321, Q - 1, 1, 4808194, 3765474, 3761513, 1'b0, none);
        add_row(CMD_INV, 123456, 7654321, Q - 1, 1, 4808194, 3765474, 3761513, 1'b0, none);
        add_row(CMD_FWD, 23'h400000, 23'h2AAAAA, 23'h555555, 23'h000001,
                23'h7FFFFE, 23'h3FFFFF, Q + 1, 1'b0, none);
        add_row(CMD_INV, Q + 1, 23'h555555, 23'h2AAAAA, 23'h400000,
                23'h000001, Q + 1, 23'h7FFFFE, 1'b0, none);

        // Reset is held from the start and released at a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            send_group(directed_rows[r].g, directed_rows[r].fixed, directed_rows[r].want);
        end
        wait_until_drained();

        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PASS; n++) begin
                g.inv = $urandom_range(1) ? CMD_INV : CMD_FWD;
                for (int k = 0; k < 4; k++) g.coef[k] = rand_operand();
                for (int k = 0; k < 3; k++) g.tw[k] = rand_operand();
                send_group(g, 1'b0, none);
            end
            // The sender holds off until every outstanding word is back.
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
